/* sv/four_level_page_table_walker_core_defines.svh */
// Assertion macros for the page table walker.
// Each expects clk and rst_n in scope; checks are off while rst_n is low.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PTW_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTW_ASSERT(lbl, ante, cons, msg)
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/ptw_pkg.sv */
`timescale 1ns / 1ps

package ptw_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_XLATE   = 2'd1;
  localparam logic [1:0] KIND_REPLACE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROOT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_ROOT   = 1'b1;

  // table geometry
  localparam int unsigned PA_W    = 48;
  localparam int unsigned DESC_W  = 64;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned FRAME_W = PA_W - 12;        // descriptor bits 47..12
  localparam int unsigned WORD_W  = FRAME_W + IDX_W;  // walk word number width
  localparam logic [1:0] LAST_LEVEL = 2'd3;
  localparam int unsigned RDONLY_BIT = 7;

  typedef struct packed {
    logic [1:0]        kind;
    logic [11:0]       word_index;
    logic [63:0]       word_data;
    logic [63:0]       virt_addr;
    logic [PA_W-1:0]   root_override;
    logic [PA_W-1:0]   new_frame;
    logic              allow_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PA_W-1:0]   phys_addr;
    logic [1:0]        stop_level;
    logic [DESC_W-1:0] final_entry;
  } out_item_t;

endpackage

/* sv/ptw_store.sv */
`timescale 1ns / 1ps

// Descriptor store: one write port, one read port, registered read data.
module ptw_store #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [ADDR_W-1:0]              rd_addr,
  output logic [ptw_pkg::DESC_W-1:0]     rd_data,
  input  logic                           wr_en,
  input  logic [ADDR_W-1:0]              wr_addr,
  input  logic [ptw_pkg::DESC_W-1:0]     wr_data
);

  logic [ptw_pkg::DESC_W-1:0] mem [DEPTH];
  logic [ptw_pkg::DESC_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/four_level_page_table_walker_core.sv */
`timescale 1ns / 1ps
// Channel   Direction  Transfer when            Payload
// in_*      input      in_valid && !in_stall    ptw_pkg::in_item_t
// out_*     output     out_valid && !out_stall  ptw_pkg::out_item_t
// cfg_*     input      cfg_wr_en                cfg_index, cfg_wr_data
//
// One item at a time. A write item writes the store in S_START when its index
// is in range; a walk makes L = 0..4 descriptor reads, each a dependent read
// of the single store read port. Replace write-back shares the last read cycle.
// After reset a clearing pass zeroes all STORE_WORDS store words, in_stall high.
// A result waits in the output register; the next item is taken meanwhile.

`include "four_level_page_table_walker_core_defines.svh"

module four_level_page_table_walker_core #(
  parameter int unsigned STORE_WORDS = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ptw_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ptw_pkg::out_item_t                    out_data,
  input  logic                                  cfg_wr_en,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ptw_pkg::PA_W-1:0]              cfg_wr_data
);

  localparam int unsigned AW = $clog2(STORE_WORDS);
  localparam logic [ptw_pkg::WORD_W-1:0] STORE_LIM = ptw_pkg::WORD_W'(STORE_WORDS);
  localparam logic [AW-1:0] CLR_LAST = AW'(STORE_WORDS - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // 9-bit table index of a level
  function automatic logic [ptw_pkg::IDX_W-1:0] idx_of(input logic [63:0] va,
                                                       input logic [1:0] lvl);
    logic [ptw_pkg::IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // page offset bits kept below the stop level
  function automatic logic [ptw_pkg::PA_W-1:0] off_mask(input logic [1:0] lvl);
    logic [ptw_pkg::PA_W-1:0] m;
    unique case (lvl)
      2'd0:    m = 48'h00_7f_ffff_ffff;
      2'd1:    m = 48'h00_00_3fff_ffff;
      2'd2:    m = 48'h00_00_001f_ffff;
      default: m = 48'h00_00_0000_0fff;
    endcase
    return m;
  endfunction

  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   lvl_r, lvl_nxt;
  logic [AW-1:0]                rd_word_r, rd_word_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  ptw_pkg::in_item_t            item_r;
  ptw_pkg::out_item_t           res_r, res_nxt;
  logic                         out_valid_r;
  ptw_pkg::out_item_t           out_data_r;
  logic [ptw_pkg::PA_W-1:0]     kernel_root_r, user_root_r;

  // store port
  logic                         rd_en, wr_en;
  logic [AW-1:0]                wr_addr;
  logic [ptw_pkg::DESC_W-1:0]   rd_data, wr_data;

  // walk datapath
  logic [ptw_pkg::PA_W-1:0]     root;
  logic [ptw_pkg::WORD_W-1:0]   start_word, next_word, probe_word;
  logic                         probe_out;
  logic                         is_walk, is_replace, wr_in_range, slot_free;
  logic [ptw_pkg::DESC_W-1:0]   mod_desc, stop_desc;
  logic [ptw_pkg::PA_W-1:0]     phys;

  ptw_store #(
    .DEPTH  (STORE_WORDS),
    .ADDR_W (AW)
  ) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (AW'(probe_word)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // root select: kernel space, per-item override, else user default
  always_comb begin
    priority if (item_r.virt_addr[63:48] == 16'hffff) begin
      root = kernel_root_r;
    end else if (item_r.root_override != '0) begin
      root = item_r.root_override;
    end else begin
      root = user_root_r;
    end
  end

  assign start_word = {root[47:12], idx_of(item_r.virt_addr, 2'd0)};
  assign next_word  = {rd_data[47:12], idx_of(item_r.virt_addr, lvl_r + 2'd1)};
  assign probe_word = (state_r == S_START) ? start_word : next_word;
  assign probe_out  = (probe_word >= STORE_LIM);

  assign is_replace  = (item_r.kind == ptw_pkg::KIND_REPLACE);
  assign is_walk     = (item_r.kind == ptw_pkg::KIND_XLATE) || is_replace;
  assign wr_in_range = (ptw_pkg::WORD_W'(item_r.word_index) < STORE_LIM);
  assign slot_free   = !out_valid_r || !out_stall;

  // replaced descriptor: new frame, read-only from write permission
  assign mod_desc  = {rd_data[63:48], item_r.new_frame[47:12], rd_data[11:8],
                      !item_r.allow_write, rd_data[6:0]};
  assign stop_desc = is_replace ? mod_desc : rd_data;
  assign phys      = {stop_desc[47:12], 12'h000} |
                     (item_r.virt_addr[47:0] & off_mask(lvl_r));

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    lvl_nxt     = lvl_r;
    rd_word_nxt = rd_word_r;
    clr_cnt_nxt = clr_cnt_r;
    res_nxt     = res_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = rd_word_r;
    wr_data     = mod_desc;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        res_nxt   = '0;
        lvl_nxt   = 2'd0;
        state_nxt = S_DONE;
        if (item_r.kind == ptw_pkg::KIND_WRITE) begin
          wr_en   = wr_in_range;
          wr_addr = AW'(item_r.word_index);
          wr_data = item_r.word_data;
        end else if (is_walk) begin
          if (probe_out) begin
            res_nxt.status = ptw_pkg::ST_OUTSIDE;
          end else begin
            rd_en       = 1'b1;
            rd_word_nxt = AW'(probe_word);
            state_nxt   = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        priority if (!rd_data[0]) begin
          // invalid descriptor
          res_nxt.status      = ptw_pkg::ST_INVALID;
          res_nxt.stop_level  = lvl_r;
          res_nxt.final_entry = rd_data;
        end else if (!rd_data[1] || lvl_r == ptw_pkg::LAST_LEVEL) begin
          // block or page: finish, write back on replace
          wr_en               = is_replace;
          res_nxt.status      = ptw_pkg::ST_OK;
          res_nxt.stop_level  = lvl_r;
          res_nxt.phys_addr   = phys;
          res_nxt.final_entry = stop_desc;
        end else if (probe_out) begin
          res_nxt.status     = ptw_pkg::ST_OUTSIDE;
          res_nxt.stop_level = lvl_r + 2'd1;
        end else begin
          // descend one level
          rd_en       = 1'b1;
          rd_word_nxt = AW'(probe_word);
          lvl_nxt     = lvl_r + 2'd1;
          state_nxt   = S_EVAL;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      lvl_r         <= '0;
      out_valid_r   <= 1'b0;
      kernel_root_r <= '0;
      user_root_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      lvl_r     <= lvl_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          ptw_pkg::CFG_KERNEL_ROOT: kernel_root_r <= cfg_wr_data;
          ptw_pkg::CFG_USER_ROOT:   user_root_r   <= cfg_wr_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    rd_word_r <= rd_word_nxt;
    res_r     <= res_nxt;
    if (state_r == S_DONE && slot_free) begin
      out_data_r <= res_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PTW_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == S_START, "transfer did not start item")
  `PTW_ASSERT_NEXT(a_no_level_wrap, state_r == S_EVAL && lvl_r == ptw_pkg::LAST_LEVEL, state_r != S_EVAL, "walk went past last level")
  `PTW_ASSERT_NEXT(a_done_emits, state_r == S_DONE && !out_valid_r, out_valid && state_r == S_IDLE, "result not presented")
  `PTW_ASSERT(a_fault_no_pa, out_valid && out_data.status != ptw_pkg::ST_OK, out_data.phys_addr == '0, "fault with nonzero address")

endmodule

/* tb/sv/tb_four_level_page_table_walker_core.sv */
`timescale 1ns / 1ps

module tb_four_level_page_table_walker_core;
  import ptw_pkg::*;

  localparam int STORE_WORDS = 4096;
  localparam int STORE_AW = $clog2(STORE_WORDS);
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 120;

  // how a generated table chain is broken, if at all
  localparam int FLAW_NONE    = 0;
  localparam int FLAW_INVALID = 1;
  localparam int FLAW_OUTSIDE = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KERNEL_ROOT;
  logic [PA_W-1:0] cfg_wr_data = '0;

  // shadow copy of the block's store and roots
  logic [DESC_W-1:0] table_mem [STORE_WORDS];
  logic [PA_W-1:0] kern_root;
  logic [PA_W-1:0] usr_root;

  in_item_t req_items[$];
  out_item_t walk_results_q[$];
  int n_accepted = 0;
  int n_mismatch = 0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic [7:0] rx_cyc = '0;

  always #2 clk = ~clk;

  four_level_page_table_walker_core #(
    .STORE_WORDS(STORE_WORDS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  // expected result of one item; updates the shadow store like the block does
  function automatic out_item_t walk_result(input in_item_t it);
    out_item_t r;
    logic [PA_W-1:0] base;
    logic [DESC_W-1:0] entry;
    logic [PA_W-1:0] off_mask;
    logic [WORD_W-1:0] w;
    logic [STORE_AW-1:0] hit;
    bit walk_done;
    r = '0;
    if (it.kind == KIND_WRITE) begin
      if (it.word_index < STORE_WORDS) table_mem[it.word_index] = it.word_data;
      return r;
    end
    if (it.kind != KIND_XLATE && it.kind != KIND_REPLACE) return r;
    if (it.virt_addr[63:48] == 16'hffff) base = kern_root;
    else if (it.root_override != '0) base = it.root_override;
    else base = usr_root;
    entry = {16'h0, base};
    off_mask = 48'h7f_ffff_ffff;
    hit = '0;
    walk_done = 1'b0;
    for (int lv = 0; lv < 4 && !walk_done; lv++) begin
      w = {entry[PA_W-1:12], it.virt_addr[47-9*lv -: 9]};
      r.stop_level = 2'(lv);
      if (w >= STORE_WORDS) begin
        r.status = ST_OUTSIDE;
        walk_done = 1'b1;
      end else begin
        hit = STORE_AW'(w);
        entry = table_mem[hit];
        if (!entry[0]) begin
          r.status = ST_INVALID;
          r.final_entry = entry;
          walk_done = 1'b1;
        end else if (!entry[1] || lv == LAST_LEVEL) begin
          walk_done = 1'b1;
        end else begin
          off_mask = off_mask >> IDX_W;
        end
      end
    end
    if (r.status != ST_OK) return r;
    // replace: new frame and write permission go back into the store
    if (it.kind == KIND_REPLACE) begin
      entry[RDONLY_BIT] = !it.allow_write;
      entry[PA_W-1:12] = it.new_frame[PA_W-1:12];
      table_mem[hit] = entry;
    end
    r.phys_addr = {entry[PA_W-1:12], 12'h0} | (it.virt_addr[PA_W-1:0] & off_mask);
    r.final_entry = entry;
    return r;
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] kind);
    in_item_t it;
    it.kind = kind;
    it.word_index = 12'($urandom);
    it.word_data = {$urandom, $urandom};
    it.virt_addr = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) it.virt_addr[63:48] = 16'hffff;
    case ($urandom_range(0, 2))
      0: it.root_override = '0;
      1: it.root_override = 48'($urandom_range(0, 32767));
      default: it.root_override = 48'({$urandom, $urandom});
    endcase
    it.new_frame = 48'({$urandom, $urandom});
    it.allow_write = 1'($urandom);
    return it;
  endfunction

  task automatic push_at(input logic [1:0] kind, input logic [63:0] va,
                         input logic [PA_W-1:0] ovr);
    in_item_t it;
    it = rand_item(kind);
    it.virt_addr = va;
    it.root_override = ovr;
    req_items.push_back(it);
  endtask

  // queue store writes that build a table chain for va down to stop_lv
  task automatic add_walk(input logic [63:0] va, input logic [PA_W-1:0] ovr,
                          input int stop_lv, input int flaw);
    in_item_t it;
    logic [PA_W-1:0] base;
    logic [DESC_W-1:0] d;
    logic [2:0] page;
    if (va[63:48] == 16'hffff) base = kern_root;
    else if (ovr != '0) base = ovr;
    else base = usr_root;
    // root already outside the store: the walk faults at the top level
    if (base[PA_W-1:15] != '0) return;
    page = base[14:12];
    for (int lv = 0; lv <= stop_lv; lv++) begin
      it = rand_item(KIND_WRITE);
      it.word_index = {page, va[47-9*lv -: 9]};
      d = {$urandom, $urandom};
      if (lv < stop_lv) begin
        page = 3'($urandom_range(0, 7));
        d[PA_W-1:12] = {33'h0, page};
        d[1:0] = 2'b11;
        if (flaw == FLAW_OUTSIDE && lv == stop_lv - 1)
          d[PA_W-1:15] = 33'({$urandom, $urandom}) | 33'd1;
      end else begin
        d[0] = (flaw != FLAW_INVALID);
        if (lv < 3) d[1] = 1'b0;
      end
      it.word_data = d;
      req_items.push_back(it);
      if (flaw == FLAW_OUTSIDE && lv == stop_lv - 1) break;
    end
  endtask

  task automatic push_directed();
    in_item_t it;
    logic [63:0] va;
    // empty store: top-level descriptor invalid
    push_at(KIND_XLATE, 64'h0, '0);
    // word index and data extremes
    it = rand_item(KIND_WRITE);
    it.word_index = '1;
    it.word_data = '1;
    req_items.push_back(it);
    it = rand_item(KIND_WRITE);
    it.word_index = '0;
    it.word_data = '0;
    req_items.push_back(it);
    // full four-level walk to a page, then replace the frame both ways
    va = 64'h0000_7fab_cdef_1234;
    add_walk(va, '0, 3, FLAW_NONE);
    push_at(KIND_XLATE, va, '0);
    it = rand_item(KIND_REPLACE);
    it.virt_addr = va;
    it.root_override = '0;
    it.new_frame = '0;
    it.allow_write = 1'b0;
    req_items.push_back(it);
    it.new_frame = '1;
    it.allow_write = 1'b1;
    req_items.push_back(it);
    push_at(KIND_XLATE, va, '0);
    // kernel address, block at level 1
    va = 64'hffff_8123_4567_89ab;
    add_walk(va, '0, 1, FLAW_NONE);
    push_at(KIND_XLATE, va, '0);
    // per-item root beyond the store
    push_at(KIND_XLATE, 64'h0000_1234_5678_9abc, '1);
    // table pointer beyond the store
    va = 64'h0000_0246_8ace_0135;
    add_walk(va, 48'h2000, 1, FLAW_OUTSIDE);
    push_at(KIND_XLATE, va, 48'h2000);
    // invalid descriptor at level 2; replace must not write
    va = 64'h0000_5555_aaaa_5000;
    add_walk(va, 48'h5000, 2, FLAW_INVALID);
    push_at(KIND_XLATE, va, 48'h5000);
    push_at(KIND_REPLACE, va, 48'h5000);
    // address extremes
    push_at(KIND_XLATE, '1, '1);
    push_at(KIND_XLATE, '0, '1);
  endtask

  task automatic fill_random(input int n_items);
    in_item_t it;
    logic [63:0] va;
    logic [PA_W-1:0] ovr;
    int stop_lv;
    int flaw;
    int n0;
    int added;
    added = 0;
    while (added < n_items) begin
      n0 = req_items.size();
      if ($urandom_range(0, 4) != 0) begin
        // well-formed chain with random content, sometimes broken
        va = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) va[63:48] = 16'hffff;
        ovr = ($urandom_range(0, 1) == 0) ? '0 : 48'($urandom_range(1, 32767));
        stop_lv = $urandom_range(0, 3);
        case ($urandom_range(0, 7))
          0: flaw = FLAW_INVALID;
          1: flaw = (stop_lv > 0) ? FLAW_OUTSIDE : FLAW_NONE;
          default: flaw = FLAW_NONE;
        endcase
        add_walk(va, ovr, stop_lv, flaw);
        repeat ($urandom_range(1, 3))
          push_at(($urandom_range(0, 1) == 0) ? KIND_XLATE : KIND_REPLACE, va, ovr);
      end else begin
        case ($urandom_range(0, 2))
          0: it = rand_item(KIND_WRITE);
          1: it = rand_item(KIND_XLATE);
          default: it = rand_item(KIND_REPLACE);
        endcase
        req_items.push_back(it);
      end
      added += req_items.size() - n0;
    end
  endtask

  // both roots written on consecutive edges; call only with nothing in flight
  task automatic set_roots(input logic [PA_W-1:0] kr, input logic [PA_W-1:0] ur);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_KERNEL_ROOT;
    cfg_wr_data <= kr;
    @(posedge clk);
    cfg_index <= CFG_USER_ROOT;
    cfg_wr_data <= ur;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    kern_root = kr;
    usr_root = ur;
  endtask

  // checked between edges, once sender and monitor have settled
  task automatic wait_drain();
    @(negedge clk);
    while (req_items.size() != 0 || in_valid || walk_results_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input logic [PA_W-1:0] kr, input logic [PA_W-1:0] ur,
                           input bit with_directed, input int n_items);
    set_roots(kr, ur);
    if (with_directed) push_directed();
    fill_random(n_items);
    wait_drain();
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $time);
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        walk_results_q.push_back(walk_result(in_data));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_items.size() != 0) begin
          in_data <= req_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: one long hold-off, otherwise a stall pattern chosen by rx_cyc[7:6]
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 8'd1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        case (rx_cyc[7:6])
          2'b00: out_stall <= 1'b0;
          2'b01: out_stall <= ($urandom_range(0, 2) == 0);
          2'b10: out_stall <= (rx_cyc[2:0] == 3'd3 || rx_cyc[2:0] == 3'd5);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (walk_results_q.size() == 0) begin
        flag_mismatch("unexpected transfer", '0, out_data.final_entry);
      end else begin
        want = walk_results_q.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch("status", 64'(want.status), 64'(out_data.status));
        if (out_data.phys_addr !== want.phys_addr)
          flag_mismatch("phys_addr", 64'(want.phys_addr), 64'(out_data.phys_addr));
        if (out_data.stop_level !== want.stop_level)
          flag_mismatch("stop_level", 64'(want.stop_level), 64'(out_data.stop_level));
        if (out_data.final_entry !== want.final_entry)
          flag_mismatch("final_entry", want.final_entry, out_data.final_entry);
      end
    end
  end

  initial begin
    foreach (table_mem[i]) table_mem[i] = '0;
    kern_root = '0;
    usr_root = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    run_phase(48'h3a5c, 48'h1000, 1'b1, 140);
    run_phase('1, '0, 1'b0, 150);
    run_phase('0, '1, 1'b0, 150);
    run_phase(48'($urandom_range(0, 32767)), 48'($urandom_range(0, 32767)), 1'b0, 150);
    repeat (20) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
